FILE: rtl/core/assert_macros.svh
// Assertion macros used by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/core/fbc64_pkg.sv
// Types, S-box and round functions of the 64-bit Feistel block cipher.
`timescale 1ns / 1ps
package fbc64_pkg;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [11:0][7:0] subkeys_t;

  typedef struct packed {
    logic        dec;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  // Subkey bytes of one round; r is an elaboration-time constant.
  function automatic subkeys_t round_subkeys(logic [63:0] key, int r);
    subkeys_t    sk;
    logic [63:0] rot;
    int          amt;
    int          idx;
    for (int s = 0; s < 12; s++) begin
      amt = (12 * r + s + 1) % 64;
      idx = (4 * r + s % 4) % 8;
      rot = (amt == 0) ? key : ((key << amt) | (key >> (64 - amt)));
      sk[s] = rot[63 - 8 * idx -: 8];
    end
    return sk;
  endfunction

  function automatic logic [15:0] gperm(logic [15:0] w, logic [7:0] k0, logic [7:0] k1,
                                        logic [7:0] k2, logic [7:0] k3);
    logic [7:0] b3, b4, b5, b6;
    b3 = SBOX[w[7:0] ^ k0] ^ w[15:8];
    b4 = SBOX[b3 ^ k1] ^ w[7:0];
    b5 = SBOX[b4 ^ k2] ^ b3;
    b6 = SBOX[b5 ^ k3] ^ b4;
    return {b5, b6};
  endfunction

  function automatic logic [15:0] rol16(logic [15:0] v);
    return {v[14:0], v[15]};
  endfunction

  function automatic logic [15:0] ror16(logic [15:0] v);
    return {v[0], v[15:1]};
  endfunction

  function automatic stage_t round_step(stage_t s, subkeys_t sk);
    stage_t      o;
    logic [15:0] t0, t1, f0, f1;
    t0 = gperm(s.w0, sk[0], sk[1], sk[2], sk[3]);
    t1 = gperm(s.w1, sk[4], sk[5], sk[6], sk[7]);
    f0 = t0 + {t1[14:0], 1'b0} + {sk[8], sk[9]};
    f1 = {t0[14:0], 1'b0} + t1 + {sk[10], sk[11]};
    o.dec = s.dec;
    o.w2  = s.w0;
    o.w3  = s.w1;
    if (s.dec == OP_DECRYPT) begin
      o.w0 = rol16(s.w2) ^ f0;
      o.w1 = ror16(s.w3 ^ f1);
    end else begin
      o.w0 = ror16(s.w2 ^ f0);
      o.w1 = rol16(s.w3) ^ f1;
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/feistel_block_cipher_64_top.sv
// Top level of the pipelined 64-bit Feistel block cipher.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One round per pipeline stage between a whitening stage and an output stage: a new
// request is taken in every cycle, and its result appears on result_block with
// result_valid for one cycle, once it has passed the whitening, round and output
// registers. The receiver cannot stall, so the pipeline never holds. busy is high only
// during reset. The key must be written only while no request is in flight.
module feistel_block_cipher_64_top
  import fbc64_pkg::*;
#(
  parameter int ROUND_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] data_block,
  output logic        result_valid,
  output logic [63:0] result_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic [63:0]             cipher_key;
  stage_t                  stage [ROUND_COUNT + 1];
  logic [ROUND_COUNT:0]    valid;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cipher_key <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage[0].dec <= opcode;
    stage[0].w0  <= data_block[63:48] ^ cipher_key[63:48];
    stage[0].w1  <= data_block[47:32] ^ cipher_key[47:32];
    stage[0].w2  <= data_block[31:16] ^ cipher_key[31:16];
    stage[0].w3  <= data_block[15:0]  ^ cipher_key[15:0];
  end

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    subkeys_t sk_enc, sk_dec, sk;

    always_comb begin
      sk_enc = round_subkeys(cipher_key, i);
      sk_dec = round_subkeys(cipher_key, ROUND_COUNT - 1 - i);
      sk     = (stage[i].dec == OP_DECRYPT) ? sk_dec : sk_enc;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i + 1] <= 1'b0;
      end else begin
        valid[i + 1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      stage[i + 1] <= round_step(stage[i], sk);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    result_block <= {stage[ROUND_COUNT].w2 ^ cipher_key[63:48],
                     stage[ROUND_COUNT].w3 ^ cipher_key[47:32],
                     stage[ROUND_COUNT].w0 ^ cipher_key[31:16],
                     stage[ROUND_COUNT].w1 ^ cipher_key[15:0]};
  end

  `ASSERT_CLK(a_latency, clk, rst, (start && !busy) |-> ##(ROUND_COUNT + 2) result_valid, "no result")
  `ASSERT_CLK(a_no_spurious, clk, rst, (!start) |-> ##(ROUND_COUNT + 2) !result_valid, "stray result")
  `ASSERT_CLK(a_valid_shift, clk, rst, valid[ROUND_COUNT] |-> $past(valid[0], ROUND_COUNT), "valid lost")
  `ASSERT_NEVER(a_cfg_in_reset, clk, rst, cfg_ready && busy, "configuration ready while busy")

endmodule

FILE: test/fbc64_checker.sv
// Checker for the 64-bit Feistel block cipher: predicts each result and compares it.
`timescale 1ns / 1ps
module fbc64_checker
  import fbc64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        opcode,
  input  logic [63:0] data_block,
  input  logic        result_valid,
  input  logic [63:0] result_block,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int ROUND_TOTAL = 16;

  localparam logic [7:0] SUB_TABLE [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  logic [63:0] key_shadow;
  logic [63:0] expected_blocks[$];

  function automatic logic [7:0] key_byte(logic [63:0] key, int rnd, int slot);
    logic [63:0] rot;
    int          amt;
    int          idx;
    amt = (12 * rnd + slot + 1) % 64;
    idx = (4 * rnd + slot % 4) % 8;
    rot = (amt == 0) ? key : ((key << amt) | (key >> (64 - amt)));
    return rot[63 - 8 * idx -: 8];
  endfunction

  function automatic logic [15:0] mix_word(logic [15:0] w, logic [63:0] key, int rnd, int base);
    logic [7:0] a, b, c, d;
    a = SUB_TABLE[w[7:0] ^ key_byte(key, rnd, base)] ^ w[15:8];
    b = SUB_TABLE[a ^ key_byte(key, rnd, base + 1)] ^ w[7:0];
    c = SUB_TABLE[b ^ key_byte(key, rnd, base + 2)] ^ a;
    d = SUB_TABLE[c ^ key_byte(key, rnd, base + 3)] ^ b;
    return {c, d};
  endfunction

  function automatic logic [63:0] cipher_block(logic [63:0] key, logic op, logic [63:0] blk);
    logic [15:0] kw[4];
    logic [15:0] w[4];
    logic [15:0] t0, t1, f0, f1, n0, n1;
    int          kr;
    for (int i = 0; i < 4; i++) begin
      kw[i] = key[63 - 16 * i -: 16];
      w[i] = blk[63 - 16 * i -: 16] ^ kw[i];
    end
    for (int r = 0; r < ROUND_TOTAL; r++) begin
      kr = (op == OP_DECRYPT) ? ROUND_TOTAL - 1 - r : r;
      t0 = mix_word(w[0], key, kr, 0);
      t1 = mix_word(w[1], key, kr, 4);
      f0 = t0 + (t1 << 1) + {key_byte(key, kr, 8), key_byte(key, kr, 9)};
      f1 = (t0 << 1) + t1 + {key_byte(key, kr, 10), key_byte(key, kr, 11)};
      if (op == OP_DECRYPT) begin
        n0 = {w[2][14:0], w[2][15]} ^ f0;
        n1 = (w[3] ^ f1) >> 1 | (w[3] ^ f1) << 15;
      end else begin
        n0 = (w[2] ^ f0) >> 1 | (w[2] ^ f0) << 15;
        n1 = {w[3][14:0], w[3][15]} ^ f1;
      end
      w[2] = w[0];
      w[3] = w[1];
      w[0] = n0;
      w[1] = n1;
    end
    return {w[2] ^ kw[0], w[3] ^ kw[1], w[0] ^ kw[2], w[1] ^ kw[3]};
  endfunction

  assign pending_count = expected_blocks.size();

  always @(posedge clk) begin
    if (rst) begin
      key_shadow <= '0;
      expected_blocks.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) key_shadow <= cfg_data;
      if (start && !busy) expected_blocks.push_back(cipher_block(key_shadow, opcode, data_block));
      if (result_valid) begin
        result_count <= result_count + 1;
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_block);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_blocks[0] !== result_block) begin
            $display("%0t: result_block mismatch, expected %h, actual %h",
                     $time, expected_blocks[0], result_block);
            fail_count <= fail_count + 1;
          end
          void'(expected_blocks.pop_front());
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
// Testbench top: drives requests and key writes into the cipher and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import fbc64_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [63:0] data_block;
  logic        result_valid;
  logic [63:0] result_block;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          idle_cycles;
  int          sent_count;
  int          gap_percent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  feistel_block_cipher_64_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .data_block   (data_block),
    .result_valid (result_valid),
    .result_block (result_block),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  fbc64_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [63:0] blk);
    while ($urandom_range(99, 0) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    data_block <= blk;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  task automatic write_key(logic [63:0] key);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] keys[6];
    logic [63:0] blk;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_ENCRYPT;
    data_block = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sent_count = 0;
    gap_percent = 0;
    keys = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0001, rand64(),
             rand64(), rand64()};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset key, then under the extreme keys.
    for (int k = 0; k < 3; k++) begin
      if (k != 0) write_key(keys[k]);
      send_request(OP_ENCRYPT, 64'h0);
      send_request(OP_DECRYPT, 64'h0);
      send_request(OP_ENCRYPT, '1);
      send_request(OP_DECRYPT, '1);
      send_request(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
      send_request(OP_DECRYPT, 64'h8000_0000_0000_0001);
      send_request(OP_ENCRYPT, 64'h5555_aaaa_5555_aaaa);
    end

    // Random phases: sender gaps at 31 percent, then 51, then none, key changed between.
    for (int p = 0; p < 3; p++) begin
      gap_percent = (p == 0) ? 31 : (p == 1) ? 51 : 0;
      write_key(keys[3 + p]);
      for (int n = 0; n < 500; n++) begin
        case ($urandom_range(9, 0))
          0: blk = '0;
          1: blk = '1;
          default: blk = rand64();
        endcase
        send_request(1'($urandom_range(1, 0)), blk);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over six keys, encrypt and decrypt mixed; %0d results checked",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
